// ----- src/hnbc_pkg.sv -----
package hnbc_pkg;

  // Default sizes of the histogram store.
  localparam int NUM_CLASSES_DEF = 7;
  localparam int HIST_BINS_DEF   = 1024;
  localparam int COUNT_WIDTH_DEF = 16;

  // Number of probability fields on the result channel.
  localparam int OUT_PROBS = 7;
  localparam int PROB_W    = 17;
  localparam int FRAC_BITS = 16;
  localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;

  // Energy bin: floor(e / 10) as (e * 52429) >> 19, exact for all 14-bit e.
  localparam int ENERGY_DIV   = 10;
  localparam int ENERGY_RECIP = 52429;
  localparam int ENERGY_SHIFT = 19;
  localparam int ENERGY_W     = 14;
  localparam int EBIN_W       = 11;

  localparam int TOTAL_W = 24;

  // Command codes.
  localparam logic CMD_TRAIN    = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_HITS = 3'd1;
  localparam logic [2:0] ST_UNTRAINED = 3'd2;
  localparam logic [2:0] ST_ZERO_SUM  = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;

endpackage

// ----- src/histogram_naive_bayes_classifier_top.sv -----
// Channel    Handshake              Payload
// in_        in_valid / in_stall    command, class_index, hit_count, cluster_count,
//                                   energy_deposit
// out_       out_valid / out_stall  prob_class0..prob_class6, status
//
// A train transfer does one memory read, then one write back of the bumped bins.
// A classify transfer takes each class through the read and the split product
// (S_CRD, S_CM1, S_CM2, S_CM3), then one quotient bit per cycle for each reported
// class after a divider load (S_DLD). Early-exit statuses skip the divider. After
// reset a clearing pass writes zero to all NUM_CLASSES * HIST_BINS bins, one
// address per cycle, while in_stall stays high.
// A finished result waits in the output register while the next item is taken in.
module histogram_naive_bayes_classifier_top
  import hnbc_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF,
  parameter int HIST_BINS   = HIST_BINS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_command,
  input  logic [2:0]          in_class_index,
  input  logic [9:0]          in_hit_count,
  input  logic [9:0]          in_cluster_count,
  input  logic [13:0]         in_energy_deposit,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PROB_W-1:0]   out_prob_class0,
  output logic [PROB_W-1:0]   out_prob_class1,
  output logic [PROB_W-1:0]   out_prob_class2,
  output logic [PROB_W-1:0]   out_prob_class3,
  output logic [PROB_W-1:0]   out_prob_class4,
  output logic [PROB_W-1:0]   out_prob_class5,
  output logic [PROB_W-1:0]   out_prob_class6,
  output logic [2:0]          out_status
);

  localparam int DEPTH = NUM_CLASSES * HIST_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(NUM_CLASSES);
  localparam int CW    = COUNT_WIDTH;
  localparam int PW    = 3 * COUNT_WIDTH;
  localparam int SW    = PW + KW;
  localparam int NOUT  = (NUM_CLASSES < OUT_PROBS) ? NUM_CLASSES : OUT_PROBS;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_TRD  = 10'b0000000100,
    S_TWR  = 10'b0000001000,
    S_CRD  = 10'b0000010000,
    S_CM1  = 10'b0000100000,
    S_CM2  = 10'b0001000000,
    S_CM3  = 10'b0010000000,
    S_DLD  = 10'b0100000000,
    S_DIV  = 10'b1000000000
  } state_t;

  // Two flags extend the idle state: a pending sum check and a result waiting
  // for the output register.
  state_t state_r, state_nxt;
  logic   chk_r, chk_nxt;     // sum check pending after the last product
  logic   done_r, done_nxt;   // result ready to move into the output register

  // Control registers.
  logic [AW-1:0]      clr_r;
  logic [KW-1:0]      k_r;
  logic [2:0]         j_r;
  logic [3:0]         b_r;
  logic [TOTAL_W-1:0] total_r;
  logic               out_valid_r;

  // Item and datapath registers.
  logic [2:0]         cls_r;
  logic [9:0]         hb_r, cb_r;
  logic [EBIN_W-1:0]  eb_r;
  logic [2:0]         status_r;
  logic [CW-1:0]      h_rd_r, c_rd_r, e_rd_r;
  logic [2*CW-1:0]    p1_r, pp_r;
  logic [CW-1:0]      e_r;
  logic [PW-1:0]      prod_r [NUM_CLASSES];
  logic [SW-1:0]      sum_r, rem_r;
  logic [FRAC_BITS-1:0] q_r;
  logic               full_r;
  logic [PROB_W-1:0]  stage_r [OUT_PROBS];
  logic [PROB_W-1:0]  out_prob_r [OUT_PROBS];
  logic [2:0]         out_status_r;

  // Memories.
  logic [CW-1:0] hit_mem [DEPTH];
  logic [CW-1:0] clu_mem [DEPTH];
  logic [CW-1:0] ene_mem [DEPTH];

  // Input decode at the transfer.
  logic [29:0]        e_mul;
  logic [EBIN_W-1:0]  in_eb;
  logic               in_range, in_cls_ok, in_xfer;

  assign e_mul     = 30'(in_energy_deposit) * 30'(ENERGY_RECIP);
  assign in_eb     = e_mul[ENERGY_SHIFT +: EBIN_W];
  assign in_range  = (32'(in_hit_count) < HIST_BINS) && (32'(in_cluster_count) < HIST_BINS)
                     && (32'(in_eb) < HIST_BINS);
  assign in_cls_ok = 32'(in_class_index) < NUM_CLASSES;
  assign in_stall  = (state_r != S_IDLE) || chk_r || done_r;
  assign in_xfer   = in_valid && !in_stall;

  // Memory addresses: the clear pointer, the training class or the class under evaluation.
  logic [31:0]   cls_sel;
  logic [AW-1:0] hit_addr, clu_addr, ene_addr;
  logic          mem_we, clearing;
  logic [CW-1:0] hit_wd, clu_wd, ene_wd;

  assign cls_sel  = (state_r == S_TRD || state_r == S_TWR) ? 32'(cls_r) : 32'(k_r);
  assign clearing = (state_r == S_CLR);
  assign hit_addr = clearing ? clr_r : AW'(cls_sel * HIST_BINS + 32'(hb_r));
  assign clu_addr = clearing ? clr_r : AW'(cls_sel * HIST_BINS + 32'(cb_r));
  assign ene_addr = clearing ? clr_r : AW'(cls_sel * HIST_BINS + 32'(eb_r));
  assign mem_we   = clearing || (state_r == S_TWR);
  assign hit_wd   = clearing ? '0 : ((h_rd_r == CNT_MAX) ? h_rd_r : h_rd_r + 1'b1);
  assign clu_wd   = clearing ? '0 : ((c_rd_r == CNT_MAX) ? c_rd_r : c_rd_r + 1'b1);
  assign ene_wd   = clearing ? '0 : ((e_rd_r == CNT_MAX) ? e_rd_r : e_rd_r + 1'b1);

  // Histogram memories, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      hit_mem[hit_addr] <= hit_wd;
      clu_mem[clu_addr] <= clu_wd;
      ene_mem[ene_addr] <= ene_wd;
    end
    h_rd_r <= hit_mem[hit_addr];
    c_rd_r <= clu_mem[clu_addr];
    e_rd_r <= ene_mem[ene_addr];
  end

  // Divider step: one quotient bit per cycle.
  logic [SW:0]          r2, r2_sub;
  logic                 q_bit;
  logic [FRAC_BITS-1:0] q_nxt;
  logic [KW-1:0]        j_idx;
  logic [PW-1:0]        prod_new;
  logic [SW-1:0]        sum_new;

  assign r2       = {rem_r, 1'b0};
  assign r2_sub   = r2 - {1'b0, sum_r};
  assign q_bit    = r2 >= {1'b0, sum_r};
  assign q_nxt    = {q_r[FRAC_BITS-2:0], q_bit};
  assign j_idx    = KW'(j_r);
  assign prod_new = PW'(pp_r) + ((PW'(p1_r[2*CW-1:CW]) * PW'(e_r)) << CW);
  assign sum_new  = sum_r + SW'(prod_new);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    chk_nxt   = chk_r;
    done_nxt  = done_r;
    unique case (state_r)
      S_CLR:  if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (done_r) begin
          if (!out_valid_r || !out_stall) done_nxt = 1'b0;
        end else if (chk_r) begin
          chk_nxt = 1'b0;
          if (sum_r == '0) done_nxt = 1'b1;
          else state_nxt = S_DLD;
        end else if (in_xfer) begin
          if (in_command == CMD_TRAIN) begin
            if (in_cls_ok && in_range) state_nxt = S_TRD;
          end else if (total_r == '0 || in_hit_count == '0 || !in_range) begin
            done_nxt = 1'b1;
          end else begin
            state_nxt = S_CRD;
          end
        end
      end
      S_TRD:  state_nxt = S_TWR;
      S_TWR:  state_nxt = S_IDLE;
      S_CRD:  state_nxt = S_CM1;
      S_CM1:  state_nxt = S_CM2;
      S_CM2:  state_nxt = S_CM3;
      S_CM3: begin
        if (k_r == KW'(NUM_CLASSES - 1)) begin
          state_nxt = S_IDLE;
          chk_nxt   = 1'b1;
        end else begin
          state_nxt = S_CRD;
        end
      end
      S_DLD:  state_nxt = S_DIV;
      S_DIV: begin
        if (b_r == 4'(FRAC_BITS - 1)) begin
          if (j_r == 3'(NOUT - 1)) begin
            state_nxt = S_IDLE;
            done_nxt  = 1'b1;
          end else begin
            state_nxt = S_DLD;
          end
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      chk_r       <= 1'b0;
      done_r      <= 1'b0;
      clr_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chk_r   <= chk_nxt;
      done_r  <= done_nxt;
      if (clearing) clr_r <= clr_r + 1'b1;
      if (state_r == S_TWR && total_r != {TOTAL_W{1'b1}}) total_r <= total_r + 1'b1;
      if (done_r && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cls_r <= in_class_index;
      hb_r  <= in_hit_count;
      cb_r  <= in_cluster_count;
      eb_r  <= in_eb;
      k_r   <= '0;
      j_r   <= '0;
      sum_r <= '0;
      for (int i = 0; i < OUT_PROBS; i++) stage_r[i] <= '0;
      if (total_r == '0) status_r <= ST_UNTRAINED;
      else if (in_hit_count == '0) status_r <= ST_ZERO_HITS;
      else if (!in_range) status_r <= ST_RANGE;
      else status_r <= ST_OK;
    end
    if (state_r == S_IDLE && chk_r && sum_r == '0) status_r <= ST_ZERO_SUM;
    if (state_r == S_CM1) begin
      p1_r <= h_rd_r * c_rd_r;
      e_r  <= e_rd_r;
    end
    if (state_r == S_CM2) pp_r <= p1_r[CW-1:0] * e_r;
    if (state_r == S_CM3) begin
      prod_r[k_r] <= prod_new;
      sum_r       <= sum_new;
      k_r         <= k_r + 1'b1;
    end
    if (state_r == S_DLD) begin
      rem_r  <= SW'(prod_r[j_idx]);
      full_r <= SW'(prod_r[j_idx]) >= sum_r;
      q_r    <= '0;
      b_r    <= '0;
    end
    if (state_r == S_DIV) begin
      rem_r <= q_bit ? r2_sub[SW-1:0] : r2[SW-1:0];
      q_r   <= q_nxt;
      b_r   <= b_r + 1'b1;
      if (b_r == 4'(FRAC_BITS - 1)) begin
        stage_r[j_r] <= full_r ? PROB_ONE : {1'b0, q_nxt};
        j_r          <= j_r + 1'b1;
      end
    end
    if (done_r && (!out_valid_r || !out_stall)) begin
      out_status_r <= status_r;
      for (int i = 0; i < OUT_PROBS; i++) begin
        out_prob_r[i] <= (status_r == ST_OK) ? stage_r[i] : '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_prob_class0 = out_prob_r[0];
  assign out_prob_class1 = out_prob_r[1];
  assign out_prob_class2 = out_prob_r[2];
  assign out_prob_class3 = out_prob_r[3];
  assign out_prob_class4 = out_prob_r[4];
  assign out_prob_class5 = out_prob_r[5];
  assign out_prob_class6 = out_prob_r[6];

  // Sum of the reported probabilities, for checking.
  logic [PROB_W+2:0] prob_sum;
  always_comb begin
    prob_sum = '0;
    for (int i = 0; i < OUT_PROBS; i++) prob_sum = prob_sum + (PROB_W+3)'(out_prob_r[i]);
  end

  // A failed classify reports no probability.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> prob_sum == '0)
    else $error("nonzero probability with error status");

  // Truncated probabilities never add up to more than one.
  a_sum_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> prob_sum <= (PROB_W+3)'(PROB_ONE))
    else $error("probabilities exceed one");

  // The partial remainder stays below the divisor while dividing.
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && !full_r |-> rem_r < sum_r)
    else $error("remainder not below divisor");

  // A successful result needs at least one trained event.
  a_trained: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_OK |-> total_r != '0)
    else $error("ok status from untrained store");

endmodule
